>>> rtl/pls_pkg.sv
// pls_pkg: shared types, codes and defaults of the positional list store
// holds the item structs, the action codes and the controller states
// no dependencies
`default_nettype none

package pls_pkg;

  localparam int unsigned CAPACITY_DEF   = 256;
  localparam int unsigned ENTRY_BITS_DEF = 32;

  // action codes carried in the action field; codes 5 to 7 are unused
  typedef enum logic [2:0] {
    ACT_READ   = 3'd0,
    ACT_INSERT = 3'd1,
    ACT_APPEND = 3'd2,
    ACT_REMOVE = 3'd3,
    ACT_FIND   = 3'd4
  } pls_action_e;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  index;
    logic [31:0] entry;
  } pls_in_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] entry_out;
    logic [7:0]  position;
    logic [8:0]  count;
  } pls_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_FIND,
    ST_REM_FIRST,
    ST_REM,
    ST_INS,
    ST_PUT,
    ST_DONE
  } pls_state_e;

endpackage

`default_nettype wire

>>> rtl/pls_store.sv
// pls_store: list storage, one write port and one read port
// read data is registered; uses nothing else
`default_nettype none

module pls_store #(
  parameter int unsigned CAPACITY   = 256,
  parameter int unsigned ENTRY_BITS = 32,
  localparam int unsigned AW = $clog2(CAPACITY)
) (
  input  wire logic                  clk_i,
  input  wire logic                  re_i,
  input  wire logic [AW-1:0]         raddr_i,
  input  wire logic                  we_i,
  input  wire logic [AW-1:0]         waddr_i,
  input  wire logic [ENTRY_BITS-1:0] wdata_i,
  output logic      [ENTRY_BITS-1:0] rdata_o
);

  logic [ENTRY_BITS-1:0] mem_q [CAPACITY];
  logic [ENTRY_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/pls_ctrl.sv
// pls_ctrl: sequencer of the positional list store
// walks the store one entry per cycle for shifts and searches; uses pls_pkg
`default_nettype none

module pls_ctrl #(
  parameter int unsigned CAPACITY   = 256,
  parameter int unsigned ENTRY_BITS = 32,
  localparam int unsigned AW   = $clog2(CAPACITY),
  localparam int unsigned CW   = $clog2(CAPACITY + 1),
  localparam int unsigned CMPW = (CW > 8) ? CW : 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire pls_pkg::pls_in_t      in_data_i,
  output logic                       res_valid_o,
  input  wire logic                  res_ready_i,
  output pls_pkg::pls_out_t          res_data_o,
  output logic                       mem_re_o,
  output logic      [AW-1:0]         mem_raddr_o,
  output logic                       mem_we_o,
  output logic      [AW-1:0]         mem_waddr_o,
  output logic      [ENTRY_BITS-1:0] mem_wdata_o,
  input  wire logic [ENTRY_BITS-1:0] mem_rdata_i
);

  import pls_pkg::*;

  pls_state_e            state_q, state_d;
  logic [AW-1:0]         cur_q, cur_d;
  logic [AW-1:0]         pos_q, pos_d;
  logic [ENTRY_BITS-1:0] val_q, val_d;
  logic [ENTRY_BITS-1:0] got_q, got_d;
  logic                  ok_q, ok_d;
  logic [CW-1:0]         count_q, count_d;

  logic [ENTRY_BITS-1:0] in_val;
  logic [AW-1:0]         idx_a;
  logic [AW-1:0]         ins_pos;
  logic [AW-1:0]         cur_next;
  logic                  idx_ok, val_nz, full, empty;
  logic                  ins_ok, ins_at_end, find_ok;
  logic                  cur_last, cur_at_pos, hit;

  // decode of the incoming item
  assign in_val     = ENTRY_BITS'(in_data_i.entry);
  assign idx_a      = AW'(in_data_i.index);
  assign idx_ok     = CMPW'(in_data_i.index) < CMPW'(count_q);
  assign val_nz     = in_val != '0;
  assign full       = count_q == CW'(CAPACITY);
  assign empty      = count_q == '0;
  assign ins_ok     = val_nz && !full && (empty || idx_ok);
  assign ins_pos    = empty ? '0 :
                      (in_data_i.action == ACT_INSERT) ? idx_a : idx_a + AW'(1);
  assign ins_at_end = CW'(ins_pos) == count_q;
  assign find_ok    = val_nz && !empty;

  // walk status
  assign cur_next   = cur_q + AW'(1);
  assign cur_last   = (CW'(cur_q) + CW'(1)) == count_q;
  assign cur_at_pos = cur_q == pos_q;
  assign hit        = mem_rdata_i == val_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (in_data_i.action)
            ACT_READ:               state_d = idx_ok ? ST_READ : ST_DONE;
            ACT_INSERT, ACT_APPEND: state_d = (ins_ok && !ins_at_end) ? ST_INS : ST_DONE;
            ACT_REMOVE:             state_d = idx_ok ? ST_REM_FIRST : ST_DONE;
            ACT_FIND:               state_d = find_ok ? ST_FIND : ST_DONE;
            default:                state_d = ST_DONE;
          endcase
        end
      end
      ST_READ: state_d = ST_DONE;
      ST_FIND: begin
        if (hit || cur_last) begin
          state_d = ST_DONE;
        end
      end
      ST_REM_FIRST, ST_REM: begin
        state_d = cur_last ? ST_DONE : ST_REM;
      end
      ST_INS: begin
        if (cur_at_pos) begin
          state_d = ST_PUT;
        end
      end
      ST_PUT: state_d = ST_DONE;
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cur_d       = cur_q;
    pos_d       = pos_q;
    val_d       = val_q;
    got_d       = got_q;
    ok_d        = ok_q;
    count_d     = count_q;
    mem_re_o    = 1'b0;
    mem_raddr_o = cur_next;
    mem_we_o    = 1'b0;
    mem_waddr_o = pos_q;
    mem_wdata_o = val_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ok_d  = 1'b0;
          got_d = '0;
          pos_d = '0;
          val_d = in_val;
          case (in_data_i.action)
            ACT_READ: begin
              mem_re_o    = idx_ok;
              mem_raddr_o = idx_a;
            end
            ACT_INSERT, ACT_APPEND: begin
              if (ins_ok) begin
                pos_d = ins_pos;
                if (ins_at_end) begin
                  // nothing to move: write straight to the tail
                  mem_we_o    = 1'b1;
                  mem_waddr_o = ins_pos;
                  mem_wdata_o = in_val;
                  count_d     = count_q + CW'(1);
                  ok_d        = 1'b1;
                end else begin
                  mem_re_o    = 1'b1;
                  mem_raddr_o = AW'(count_q - CW'(1));
                  cur_d       = AW'(count_q - CW'(1));
                end
              end
            end
            ACT_REMOVE: begin
              mem_re_o    = idx_ok;
              mem_raddr_o = idx_a;
              cur_d       = idx_a;
            end
            ACT_FIND: begin
              mem_re_o    = find_ok;
              mem_raddr_o = '0;
              cur_d       = '0;
            end
            default: begin
              ok_d = 1'b0;
            end
          endcase
        end
      end
      ST_READ: begin
        ok_d  = 1'b1;
        got_d = mem_rdata_i;
      end
      ST_FIND: begin
        if (hit) begin
          ok_d  = 1'b1;
          pos_d = cur_q;
        end else if (!cur_last) begin
          mem_re_o = 1'b1;
          cur_d    = cur_next;
        end
      end
      ST_REM_FIRST: begin
        ok_d  = 1'b1;
        got_d = mem_rdata_i;
        if (cur_last) begin
          count_d = count_q - CW'(1);
        end else begin
          mem_re_o = 1'b1;
          cur_d    = cur_next;
        end
      end
      ST_REM: begin
        // entry at cur moves down one place
        mem_we_o    = 1'b1;
        mem_waddr_o = cur_q - AW'(1);
        mem_wdata_o = mem_rdata_i;
        if (cur_last) begin
          count_d = count_q - CW'(1);
        end else begin
          mem_re_o = 1'b1;
          cur_d    = cur_next;
        end
      end
      ST_INS: begin
        // entry at cur moves up one place, walking down to the gap
        mem_we_o    = 1'b1;
        mem_waddr_o = cur_next;
        mem_wdata_o = mem_rdata_i;
        if (!cur_at_pos) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = cur_q - AW'(1);
          cur_d       = cur_q - AW'(1);
        end
      end
      ST_PUT: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = pos_q;
        mem_wdata_o = val_q;
        count_d     = count_q + CW'(1);
        ok_d        = 1'b1;
      end
      ST_DONE: begin
        ok_d = ok_q;
      end
      default: begin
        ok_d = ok_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      ok_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ok_q    <= ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    pos_q <= pos_d;
    val_q <= val_d;
    got_q <= got_d;
  end

  assign in_stall_o           = state_q != ST_IDLE;
  assign res_valid_o          = state_q == ST_DONE;
  assign res_data_o.ok        = ok_q;
  assign res_data_o.entry_out = 32'(got_q);
  assign res_data_o.position  = 8'(pos_q);
  assign res_data_o.count     = 9'(count_q);

endmodule

`default_nettype wire

>>> rtl/positional_list_store_top.sv
// positional_list_store_top: ordered list of entries kept in one memory
// uses pls_pkg, pls_ctrl and pls_store
//
// usage
//   input channel: in_valid_i / in_stall_o / in_data_i carry one request item
//   (action, index, entry); it is taken on a clock edge with valid high and
//   stall low. output channel: out_valid_o / out_stall_i / out_data_o carry
//   one result item (ok, entry_out, position, count) per request.
//   the block works on one item at a time; stall stays high from acceptance
//   until the result has been handed to the output register, and the next
//   item can be taken on the edge after that hand-off
// steps from the accepting edge to the result in the output register
//   read: one store read; find: walk from the head to the first hit or end
//   insert/append: shift up the entries from the position on, then write the
//   entry (at once at the tail); remove: shift down the entries above the
//   index; rejected requests skip the store. shifts and searches are paced
//   by the single read and write port of the store, one entry per cycle
// reset
//   the list is empty after reset; the store is not cleared, since only
//   positions below the count are read
// back pressure
//   a result waits in the output register while out_stall_i is high; the
//   next request is accepted meanwhile and its result waits in the
//   sequencer until the output register is free
`default_nettype none

module positional_list_store_top #(
  parameter int unsigned CAPACITY   = pls_pkg::CAPACITY_DEF,
  parameter int unsigned ENTRY_BITS = pls_pkg::ENTRY_BITS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire pls_pkg::pls_in_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output pls_pkg::pls_out_t      out_data_o
);

  import pls_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);

  // memory port between sequencer and store
  logic                  mem_re;
  logic [AW-1:0]         mem_raddr;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [ENTRY_BITS-1:0] mem_wdata;
  logic [ENTRY_BITS-1:0] mem_rdata;

  // result hand-off into the output register
  logic     res_valid;
  logic     res_ready;
  pls_out_t res_data;

  logic     out_valid_q, out_valid_d;
  pls_out_t out_data_q;

  pls_ctrl #(
    .CAPACITY   (CAPACITY),
    .ENTRY_BITS (ENTRY_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_data_o  (res_data),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_rdata_i (mem_rdata)
  );

  pls_store #(
    .CAPACITY   (CAPACITY),
    .ENTRY_BITS (ENTRY_BITS)
  ) u_store (
    .clk_i   (clk_i),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // output register: free when empty or being drained this cycle
  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_data_q <= res_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

>>> rtl/pls_checker.sv
// pls_checker: port-level checks of the positional list store
// bound to positional_list_store_top; uses pls_pkg
`default_nettype none

module pls_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire pls_pkg::pls_in_t  in_data_i,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire pls_pkg::pls_out_t out_data_o
);

  // a held result keeps its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // one item in flight: an accepted item closes the input until it is done
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("item accepted while another is in flight");

  // a failed operation reports no entry and no position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.ok |->
      out_data_o.entry_out == '0 && out_data_o.position == '0)
    else $error("failed result carries data");

  // no result is shown during reset
  assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

endmodule

bind positional_list_store_top pls_checker u_pls_checker (.*);

`default_nettype wire

>>> tb/sv/tb.sv
// tb: self-checking bench for positional_list_store_top
// drives request items through a directed table and random phases, predicts each result
// depends on pls_pkg and positional_list_store_top
`default_nettype none

module tb;
  import pls_pkg::*;

  localparam int unsigned CAP          = CAPACITY_DEF;
  localparam int unsigned N_PROBE      = 26;
  localparam int unsigned N_RANDOM     = 1425;
  localparam int unsigned LONG_HOLD    = 600;
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT  = 3000000;

  // action codes the block does not know
  localparam logic [2:0] ACT_BAD_LO  = 3'd5;
  localparam logic [2:0] ACT_BAD_MID = 3'd6;
  localparam logic [2:0] ACT_BAD_HI  = 3'd7;

  typedef enum {MODE_GROW, MODE_FULL, MODE_SHRINK, MODE_MIX} load_mode_e;

  typedef struct {
    pls_in_t  req;
    bit       typed;
    pls_out_t res;
  } probe_row_t;

  logic     clk       = 1'b0;
  logic     rst_n;
  logic     in_valid  = 1'b0;
  pls_in_t  in_data   = '0;
  logic     out_stall = 1'b0;
  logic     in_stall_o;
  logic     out_valid_o;
  pls_out_t out_data_o;

  // shadow copy of the list
  logic [31:0] model_list [CAP];
  logic [8:0]  model_cnt = '0;

  pls_out_t    awaited_results [$];
  int unsigned sent_cnt  = 0;
  int unsigned errors    = 0;
  int unsigned cycle_cnt = 0;

  // directed part: typed results on empty-list, failure and extreme rows only
  probe_row_t probe_tab [N_PROBE] = '{
    '{'{ACT_READ,    8'd0,   32'd0},          1'b1, '{1'b0, 32'd0, 8'd0, 9'd0}},
    '{'{ACT_REMOVE,  8'd0,   32'd0},          1'b1, '{1'b0, 32'd0, 8'd0, 9'd0}},
    '{'{ACT_INSERT,  8'd0,   32'd0},          1'b1, '{1'b0, 32'd0, 8'd0, 9'd0}},
    '{'{ACT_FIND,    8'd0,   32'd0},          1'b1, '{1'b0, 32'd0, 8'd0, 9'd0}},
    '{'{ACT_APPEND,  8'd255, 32'hFFFF_FFFF},  1'b1, '{1'b1, 32'd0, 8'd0, 9'd1}},
    '{'{ACT_INSERT,  8'd128, 32'd1},          1'b1, '{1'b0, 32'd0, 8'd0, 9'd1}},
    '{'{ACT_APPEND,  8'd0,   32'd1},          1'b0, '0},
    '{'{ACT_INSERT,  8'd0,   32'h8000_0000},  1'b0, '0},
    '{'{ACT_READ,    8'd0,   32'd0},          1'b0, '0},
    '{'{ACT_READ,    8'd2,   32'd0},          1'b0, '0},
    '{'{ACT_READ,    8'd3,   32'd0},          1'b1, '{1'b0, 32'd0, 8'd0, 9'd3}},
    '{'{ACT_FIND,    8'd0,   32'hFFFF_FFFF},  1'b0, '0},
    '{'{ACT_FIND,    8'd0,   32'd5},          1'b1, '{1'b0, 32'd0, 8'd0, 9'd3}},
    '{'{ACT_BAD_LO,  8'd0,   32'd1},          1'b1, '{1'b0, 32'd0, 8'd0, 9'd3}},
    '{'{ACT_BAD_MID, 8'd1,   32'h8000_0000},  1'b1, '{1'b0, 32'd0, 8'd0, 9'd3}},
    '{'{ACT_BAD_HI,  8'd255, 32'hFFFF_FFFF},  1'b1, '{1'b0, 32'd0, 8'd0, 9'd3}},
    '{'{ACT_REMOVE,  8'd1,   32'd0},          1'b0, '0},
    '{'{ACT_REMOVE,  8'd255, 32'd0},          1'b1, '{1'b0, 32'd0, 8'd0, 9'd2}},
    '{'{ACT_APPEND,  8'd1,   32'hAAAA_5555},  1'b0, '0},
    '{'{ACT_INSERT,  8'd2,   32'h5555_AAAA},  1'b0, '0},
    '{'{ACT_FIND,    8'd0,   32'hAAAA_5555},  1'b0, '0},
    '{'{ACT_REMOVE,  8'd3,   32'd0},          1'b0, '0},
    '{'{ACT_REMOVE,  8'd0,   32'd0},          1'b0, '0},
    '{'{ACT_REMOVE,  8'd0,   32'd0},          1'b0, '0},
    '{'{ACT_REMOVE,  8'd0,   32'd0},          1'b0, '0},
    '{'{ACT_INSERT,  8'd200, 32'd7},          1'b1, '{1'b1, 32'd0, 8'd0, 9'd1}}
  };

  positional_list_store_top uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o)
  );

  always #2 clk = ~clk;

  // apply one request to the shadow list and return the result it gives
  function automatic pls_out_t list_apply(pls_in_t req);
    pls_out_t    r;
    int unsigned idx;
    int unsigned pos;
    r   = '0;
    idx = req.index;
    pos = 0;
    case (req.action)
      ACT_READ: begin
        if (idx < model_cnt) begin
          r.ok        = 1'b1;
          r.entry_out = model_list[idx];
        end
      end
      ACT_INSERT, ACT_APPEND: begin
        if (req.entry != '0 && model_cnt < CAP && (model_cnt == 0 || idx < model_cnt)) begin
          // empty list takes the entry at the head whatever the index
          if (model_cnt != 0)
            pos = (req.action == ACT_INSERT) ? idx : idx + 1;
          for (int i = model_cnt; i > pos; i--)
            model_list[i] = model_list[i - 1];
          model_list[pos] = req.entry;
          model_cnt++;
          r.ok       = 1'b1;
          r.position = pos[7:0];
        end
      end
      ACT_REMOVE: begin
        if (idx < model_cnt) begin
          r.ok        = 1'b1;
          r.entry_out = model_list[idx];
          for (int i = idx; i + 1 < model_cnt; i++)
            model_list[i] = model_list[i + 1];
          model_cnt--;
        end
      end
      ACT_FIND: begin
        // null never matches
        if (req.entry != '0) begin
          for (int i = 0; i < model_cnt; i++) begin
            if (!r.ok && model_list[i] == req.entry) begin
              r.ok       = 1'b1;
              r.position = i[7:0];
            end
          end
        end
      end
      default: ;
    endcase
    r.count = model_cnt;
    return r;
  endfunction

  function automatic logic [2:0] pick_action(load_mode_e mode);
    int unsigned r;
    int unsigned c_ins, c_app, c_rem, c_rd, c_find;
    r = $urandom_range(0, 99);
    case (mode)
      MODE_GROW:   begin c_ins = 40; c_app = 70; c_rem = 76; c_rd = 84; c_find = 96; end
      MODE_FULL:   begin c_ins = 35; c_app = 60; c_rem = 70; c_rd = 78; c_find = 95; end
      MODE_SHRINK: begin c_ins = 8;  c_app = 16; c_rem = 66; c_rd = 76; c_find = 96; end
      default:     begin c_ins = 20; c_app = 40; c_rem = 60; c_rd = 78; c_find = 96; end
    endcase
    if (r < c_ins)  return ACT_INSERT;
    if (r < c_app)  return ACT_APPEND;
    if (r < c_rem)  return ACT_REMOVE;
    if (r < c_rd)   return ACT_READ;
    if (r < c_find) return ACT_FIND;
    return 3'($urandom_range(ACT_BAD_LO, ACT_BAD_HI));
  endfunction

  // mostly a live position, sometimes anything the field holds
  function automatic logic [7:0] pick_index();
    if (model_cnt != 0 && $urandom_range(0, 99) >= 8)
      return 8'($urandom_range(0, model_cnt - 1));
    return 8'($urandom_range(0, 255));
  endfunction

  // null, a value already held, a small value that repeats, or anything
  function automatic logic [31:0] pick_entry();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0)
      return '0;
    if (r <= 3 && model_cnt != 0)
      return model_list[$urandom_range(0, model_cnt - 1)];
    if (r <= 5)
      return 32'($urandom_range(1, 12));
    return $urandom;
  endfunction

  // periodic stretches where the sender leaves no gaps and the receiver adds no random stalls
  function automatic bit burst_window();
    return (sent_cnt % 256) >= 224;
  endfunction

  // mostly short gaps, a few long ones; a stall length is never zero
  function automatic int unsigned idle_len(bit for_stall);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!for_stall && r < 65)
      return 0;
    if (r < 93)
      return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_item(input pls_in_t req, input bit typed, input pls_out_t typed_res);
    pls_out_t    res;
    int unsigned gap;
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall_o);
    res = list_apply(req);
    awaited_results.push_back(typed ? typed_res : res);
    sent_cnt++;
    gap = burst_window() ? 0 : idle_len(1'b0);
    if (gap != 0) begin
      in_valid <= 1'b0;
      in_data  <= pls_in_t'({$urandom, $urandom});
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop offering and wait for every outstanding result
  task automatic wait_results_home();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    pls_in_t     req;
    load_mode_e  mode;
    int unsigned full_left;
    // falling edge on the reset so the asynchronous reset takes at once
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int k = 0; k < N_PROBE; k++)
      send_item(probe_tab[k].req, probe_tab[k].typed, probe_tab[k].res);
    wait_results_home();

    // fill to capacity, dwell at full, drain to empty, then mixed traffic
    mode      = MODE_GROW;
    full_left = 0;
    for (int k = 0; k < N_RANDOM; k++) begin
      req.action = pick_action(mode);
      req.index  = pick_index();
      req.entry  = pick_entry();
      send_item(req, 1'b0, '0);
      if (k == N_RANDOM / 2)
        wait_results_home();
      case (mode)
        MODE_GROW: begin
          if (model_cnt == CAP) begin
            mode      = MODE_FULL;
            full_left = 60;
          end
        end
        MODE_FULL: begin
          full_left--;
          if (full_left == 0)
            mode = MODE_SHRINK;
        end
        MODE_SHRINK: begin
          if (model_cnt == 0)
            mode = MODE_MIX;
        end
        default: ;
      endcase
    end

    wait_results_home();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // receiver: random stalls, quiet in burst windows, two long hold-offs that
  // back the block up into its input while the sender keeps offering
  initial begin : receiver
    int unsigned len;
    int unsigned holds;
    holds = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (holds < 2 && sent_cnt >= 400 + 600 * holds) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        holds++;
        out_stall <= 1'b0;
      end else if (burst_window() || $urandom_range(0, 2) != 0) begin
        out_stall <= 1'b0;
      end else begin
        len = idle_len(1'b1);
        out_stall <= 1'b1;
        repeat (len) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // compare each accepted result with the oldest prediction
  always @(posedge clk) begin : result_check
    pls_out_t want;
    if (rst_n && out_valid_o && !out_stall) begin
      if (awaited_results.size() == 0) begin
        $error("result with nothing outstanding: %p", out_data_o);
        errors++;
      end else begin
        want = awaited_results.pop_front();
        if (out_data_o.ok !== want.ok) begin
          $error("ok: expected %0d, got %0d", want.ok, out_data_o.ok);
          errors++;
        end
        if (out_data_o.entry_out !== want.entry_out) begin
          $error("entry_out: expected %h, got %h", want.entry_out, out_data_o.entry_out);
          errors++;
        end
        if (out_data_o.position !== want.position) begin
          $error("position: expected %0d, got %0d", want.position, out_data_o.position);
          errors++;
        end
        if (out_data_o.count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, out_data_o.count);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

endmodule

`default_nettype wire
